FILE: rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Types and constants shared by the stream pattern replace block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package spr_pkg;

    // Result beats per input item, and replacement capacity
    localparam int BURST_DEPTH = 8;
    localparam int BURST_IDX_W = 3;
    localparam int CNT_W       = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 4'd3;

    typedef struct packed {
        logic       end_mark;
        logic [7:0] data_byte;
    } spr_in_t;

    typedef struct packed {
        logic       stream_done;
        logic       run_last;
        logic       byte_valid;
        logic [7:0] out_byte;
    } spr_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } spr_cfg_t;

endpackage

FILE: rtl/core/spr_stream_if.sv
// ----------------------------------------------------------------------------
// spr_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface spr_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

FILE: rtl/core/stream_pattern_replace.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Streaming find-and-replace: leftmost non-overlapping hits of a 1..8 byte
// pattern are replaced by a 0..8 byte replacement; other bytes pass through.
// ----------------------------------------------------------------------------
//
//  channel     dir  payload                                    beat
//  in_stream   in   data_byte, end_mark                        one stream byte
//  out_stream  out  out_byte, byte_valid, run_last, stream_done one result
//  cfg_wr      in   index, data                                one register write
//
//  One byte per cycle while each byte yields at most one result and the output
//  is not stalled. A byte that yields more than one result (replacement or end
//  flush) holds the input while the single burst register drains one beat per cycle while the output takes it.
//  Results pass through the burst register and then the output register.
//  Reset empties the window, the burst and the output register, and loads
//  the configuration defaults (pattern length 1, replacement empty).
//  A stalled output holds one beat in the output register; one more item
//  can still be taken into the burst register behind it.
//
module stream_pattern_replace #(
    parameter int MAX_PATTERN = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    spr_stream_if.sink   in_stream,
    spr_stream_if.source out_stream,
    spr_stream_if.sink   cfg_wr
);

    import spr_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    // Configuration
    logic [63:0]       pattern_bytes_reg;
    logic [3:0]        pattern_length_reg;
    logic [63:0]       replacement_bytes_reg;
    logic [3:0]        replacement_length_reg;

    // Window
    logic [7:0]        window_reg [MAX_PATTERN];
    logic [7:0]        window_next [MAX_PATTERN];
    logic [FILL_W-1:0] window_fill_reg;
    logic [FILL_W-1:0] window_fill_next;

    // Burst of results for the last accepted byte
    logic [7:0]             burst_bytes_reg [BURST_DEPTH];
    logic [7:0]             burst_bytes_next [BURST_DEPTH];
    logic [CNT_W-1:0]       burst_cnt_reg;
    logic [CNT_W-1:0]       burst_cnt_next;
    logic [BURST_IDX_W-1:0] burst_idx_reg;
    logic                   burst_vld_reg;
    logic                   burst_bval_reg;
    logic                   burst_bval_next;
    logic                   burst_end_reg;

    // Output register
    spr_out_t out_reg;
    logic     out_vld_reg;

    // Combinational step
    logic [3:0]        plen4;
    logic [FILL_W-1:0] plen;
    logic [3:0]        rlen;
    logic [7:0]        app [MAX_PATTERN];
    logic [7:0]        shifted [MAX_PATTERN];
    logic [7:0]        pad [BURST_DEPTH];
    logic [FILL_W-1:0] nfill;
    logic              full;
    logic              hit;
    logic              in_end;
    logic              in_acc;
    logic              burst_load;
    logic              burst_last;
    logic              out_load;

    // Effective lengths
    always_comb
    begin
        plen4 = pattern_length_reg;
        if (plen4 == 4'd0)
        begin
            plen4 = 4'd1;
        end
        if (plen4 > 4'(MAX_PATTERN))
        begin
            plen4 = 4'(MAX_PATTERN);
        end
        plen = FILL_W'(plen4);
        rlen = (replacement_length_reg > 4'd8) ? 4'd8 : replacement_length_reg;
    end

    // Window with the new byte appended
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            app[j] = (FILL_W'(j) == window_fill_reg) ? in_stream.payload.data_byte
                                                     : window_reg[j];
        end
    end

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_shift
        if (j + 1 < MAX_PATTERN)
        begin : g_mid
            assign shifted[j] = app[j + 1];
        end
        else
        begin : g_top
            assign shifted[j] = app[j];
        end
    end

    for (genvar j = 0; j < BURST_DEPTH; j++)
    begin : g_pad
        if (j < MAX_PATTERN)
        begin : g_used
            assign pad[j] = app[j];
        end
        else
        begin : g_unused
            assign pad[j] = 8'd0;
        end
    end

    assign nfill  = window_fill_reg + FILL_W'(1);
    assign full   = (nfill >= plen);
    assign in_end = in_stream.payload.end_mark;

    always_comb
    begin
        hit = full;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((FILL_W'(i) < plen) && (app[i] != pattern_bytes_reg[8*i +: 8]))
            begin
                hit = 1'b0;
            end
        end
    end

    // Result burst: on a miss the emitted bytes are the appended window itself
    // (oldest byte, then the flush if the stream ends here)
    always_comb
    begin
        burst_bval_next = 1'b1;
        if (hit)
        begin
            burst_cnt_next = rlen;
        end
        else if (in_end)
        begin
            burst_cnt_next = CNT_W'(nfill);
        end
        else if (full)
        begin
            burst_cnt_next = CNT_W'(1);
        end
        else
        begin
            burst_cnt_next = '0;
        end
        // empty end marker
        if (in_end && burst_cnt_next == '0)
        begin
            burst_cnt_next  = CNT_W'(1);
            burst_bval_next = 1'b0;
        end
        for (int j = 0; j < BURST_DEPTH; j++)
        begin
            burst_bytes_next[j] = hit ? replacement_bytes_reg[8*j +: 8] : pad[j];
        end
    end

    // Window update
    always_comb
    begin
        window_next      = window_reg;
        window_fill_next = window_fill_reg;
        if (in_acc)
        begin
            if (in_end || hit)
            begin
                window_next      = app;
                window_fill_next = '0;
            end
            else if (full)
            begin
                window_next      = shifted;
                window_fill_next = plen - FILL_W'(1);
            end
            else
            begin
                window_next      = app;
                window_fill_next = nfill;
            end
        end
    end

    // Handshakes
    assign burst_last = (CNT_W'(burst_idx_reg) + CNT_W'(1) == burst_cnt_reg);
    assign out_load   = burst_vld_reg && (!out_vld_reg || out_stream.ready);
    assign in_stream.ready = !burst_vld_reg || (out_load && burst_last);
    assign in_acc     = in_stream.valid && in_stream.ready;
    assign burst_load = in_acc && (hit || full || in_end) && (burst_cnt_next != '0);
    assign cfg_wr.ready = 1'b1;

    assign out_stream.valid   = out_vld_reg;
    assign out_stream.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            window_fill_reg        <= '0;
            burst_vld_reg          <= 1'b0;
            burst_idx_reg          <= '0;
            out_vld_reg            <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                window_reg[j] <= 8'd0;
            end
        end
        else
        begin
            // pattern writes are dropped while bytes sit in the window
            if (cfg_wr.valid)
            begin
                case (cfg_wr.payload.index)
                    CFG_PATTERN_BYTES:
                    begin
                        if (window_fill_reg == '0)
                        begin
                            pattern_bytes_reg <= cfg_wr.payload.data;
                        end
                    end
                    CFG_PATTERN_LENGTH:
                    begin
                        if (window_fill_reg == '0)
                        begin
                            pattern_length_reg <= cfg_wr.payload.data[3:0];
                        end
                    end
                    CFG_REPLACEMENT_BYTES:
                    begin
                        replacement_bytes_reg <= cfg_wr.payload.data;
                    end
                    CFG_REPLACEMENT_LENGTH:
                    begin
                        replacement_length_reg <= cfg_wr.payload.data[3:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            window_reg      <= window_next;
            window_fill_reg <= window_fill_next;

            if (burst_load)
            begin
                burst_vld_reg <= 1'b1;
                burst_idx_reg <= '0;
            end
            else if (out_load && burst_last)
            begin
                burst_vld_reg <= 1'b0;
            end
            else if (out_load)
            begin
                burst_idx_reg <= burst_idx_reg + BURST_IDX_W'(1);
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_stream.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (burst_load)
        begin
            burst_bytes_reg <= burst_bytes_next;
            burst_cnt_reg   <= burst_cnt_next;
            burst_bval_reg  <= burst_bval_next;
            burst_end_reg   <= in_end;
        end
        if (out_load)
        begin
            out_reg.out_byte    <= burst_bval_reg ? burst_bytes_reg[burst_idx_reg] : 8'd0;
            out_reg.byte_valid  <= burst_bval_reg;
            out_reg.run_last    <= burst_last;
            out_reg.stream_done <= burst_last && burst_end_reg;
        end
    end

    // Assertions
    a_fill_below_plen: assert property (
        @(posedge clk) disable iff (!rst_n)
        window_fill_reg < plen
    ) else $error("window fill reached pattern length");

    a_idx_in_burst: assert property (
        @(posedge clk) disable iff (!rst_n)
        burst_vld_reg |-> (CNT_W'(burst_idx_reg) < burst_cnt_reg)
    ) else $error("burst index past burst count");

    a_end_clears_window: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_acc && in_end) |=> (window_fill_reg == '0)
    ) else $error("window not flushed at end of stream");

    a_done_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.stream_done) |-> out_reg.run_last
    ) else $error("stream done without run last");

    a_marker_is_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.byte_valid) |-> (out_reg.stream_done && out_reg.out_byte == 8'd0)
    ) else $error("empty beat that is not the end marker");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stream_pattern_replace. A queue-fed driver pushes
// byte streams, a monitor predicts the find-and-replace output per accepted
// beat and checks every result beat in order. Runs through directed corner
// streams, then random configurations with mostly pattern-rich streams.
// ----------------------------------------------------------------------------
module testbench;
    import spr_pkg::*;

    localparam int MAX_PAT     = 8;
    localparam int NUM_PHASES  = 20;
    localparam int PHASE_ITEMS = 17;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;

    // index the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;

    logic clk;
    logic rst_n;

    spr_stream_if #(.payload_t(spr_in_t))  in_if ();
    spr_stream_if #(.payload_t(spr_out_t)) out_if ();
    spr_stream_if #(.payload_t(spr_cfg_t)) cfg_if ();

    stream_pattern_replace #(
        .MAX_PATTERN (MAX_PAT)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_wr     (cfg_if)
    );

    // predictor copy of the configuration and the match window
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rep_bytes;
    logic [3:0]  rep_len;
    logic [7:0]  win_bytes [MAX_PAT];
    int          win_count;

    spr_in_t     pending_bytes  [$];
    spr_out_t    expected_beats [$];
    logic [7:0]  alphabet [3];

    int          src_idle_pct;
    int          sink_idle_pct;
    logic        in_taken;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_pat_len();
        int n;
        n = pat_len;
        if (n == 0) n = 1;
        if (n > MAX_PAT) n = MAX_PAT;
        return n;
    endfunction

    function automatic spr_out_t data_beat(input logic [7:0] b, input logic v);
        spr_out_t r;
        r = '0;
        r.out_byte   = b;
        r.byte_valid = v;
        return r;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        // pattern registers are locked while a partial match sits in the window
        case (idx)
            CFG_PATTERN_BYTES:      if (win_count == 0) pat_bytes = data;
            CFG_PATTERN_LENGTH:     if (win_count == 0) pat_len = data[3:0];
            CFG_REPLACEMENT_BYTES:  rep_bytes = data;
            CFG_REPLACEMENT_LENGTH: rep_len = data[3:0];
            default: ;
        endcase
    endtask

    task automatic predict_replace(input spr_in_t beat);
        spr_out_t burst [$];
        spr_out_t tail;
        int       plen;
        int       rlen;
        int       i;
        logic     hit;
        plen = eff_pat_len();
        rlen = (rep_len > 8) ? 8 : int'(rep_len);
        if (win_count >= MAX_PAT) win_count = MAX_PAT - 1;
        win_bytes[win_count] = beat.data_byte;
        win_count++;
        if (win_count >= plen)
        begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
                if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
            if (hit)
            begin
                for (i = 0; i < rlen; i++)
                    burst.insert(burst.size(), data_beat(rep_bytes[8*i +: 8], 1'b1));
                win_count = 0;
            end
            else
            begin
                burst.insert(burst.size(), data_beat(win_bytes[0], 1'b1));
                for (i = 1; i < win_count; i++)
                    win_bytes[i-1] = win_bytes[i];
                win_count--;
            end
        end
        if (beat.end_mark)
        begin
            for (i = 0; i < win_count; i++)
                burst.insert(burst.size(), data_beat(win_bytes[i], 1'b1));
            win_count = 0;
            // empty end marker when the stream closes with nothing left
            if (burst.size() == 0) burst.insert(0, data_beat(8'h00, 1'b0));
            tail = burst.pop_back();
            tail.stream_done = 1'b1;
            burst.insert(burst.size(), tail);
        end
        if (burst.size() > 0)
        begin
            tail = burst.pop_back();
            tail.run_last = 1'b1;
            burst.insert(burst.size(), tail);
        end
        foreach (burst[k]) expected_beats.insert(expected_beats.size(), burst[k]);
    endtask

    task automatic note_failure(input string what, input spr_out_t want,
                                input spr_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: exp byte %02h valid %b last %b done %b, got byte %02h valid %b last %b done %b",
                     $time, what, want.out_byte, want.byte_valid, want.run_last,
                     want.stream_done, got.out_byte, got.byte_valid, got.run_last,
                     got.stream_done);
    endtask

    task automatic check_beat(input spr_out_t got);
        spr_out_t want;
        if (expected_beats.size() == 0)
        begin
            note_failure("result beat with nothing expected", '0, got);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.run_last !== want.run_last || got.stream_done !== want.stream_done)
                note_failure("result beat mismatch", want, got);
        end
    endtask

    // monitor: inputs predicted and outputs checked on the rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            win_count = 0;
            foreach (win_bytes[j]) win_bytes[j] = 8'h00;
        end
        else
        begin
            in_taken <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) predict_replace(in_if.payload);
            if (out_if.valid && out_if.ready) check_beat(out_if.payload);
        end
    end

    // driver: valid holds until the beat is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_if.valid   <= 1'b0;
            in_if.payload <= '0;
            out_if.ready  <= 1'b0;
        end
        else
        begin
            if (!in_if.valid || in_taken)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_if.payload <= pending_bytes.pop_front();
                    in_if.valid   <= 1'b1;
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.payload <= spr_cfg_t'{index: idx, data: data};
        cfg_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        apply_write(idx, data);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        pending_bytes.insert(pending_bytes.size(), spr_in_t'{end_mark: last, data_byte: b});
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_if.valid || expected_beats.size() != 0)
            @(negedge clk);
        // an item with no result may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct  = 26;
                sink_idle_pct = 50;
            end
            1:
            begin
                src_idle_pct  = 50;
                sink_idle_pct = 26;
            end
            default:
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    task automatic random_config(input int phase);
        logic [3:0]  plen;
        logic [3:0]  rlen;
        logic [63:0] pbytes;
        int          i;
        for (i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(255));
        case (phase)
            0:
            begin
                plen = 4'd8;
                rlen = 4'd8;
            end
            1:
            begin
                plen = 4'd1;
                rlen = 4'd0;
            end
            default:
            begin
                plen = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(1, 8));
                rlen = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(0, 8));
            end
        endcase
        // small alphabet gives self-overlapping patterns and frequent partial hits
        for (i = 0; i < 8; i++) pbytes[8*i +: 8] = alphabet[$urandom_range(2)];
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
        write_reg(CFG_PATTERN_BYTES, pbytes);
        write_reg(CFG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
        write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
        write_reg(CFG_REPLACEMENT_LENGTH, {$urandom, 28'($urandom), rlen});
    endtask

    task automatic random_streams(input int count);
        logic [7:0] stream [$];
        logic       closed;
        int         made;
        int         len;
        int         plen;
        int         i;
        int         k;
        int         r;
        made = 0;
        plen = eff_pat_len();
        while (made < count)
        begin
            stream.delete();
            len = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 20);
            while (stream.size() < len)
            begin
                r = $urandom_range(99);
                if (r < 35)
                begin
                    for (i = 0; i < plen; i++)
                        stream.insert(stream.size(), pat_bytes[8*i +: 8]);
                end
                else if (r < 50 && plen > 1)
                begin
                    k = $urandom_range(1, plen - 1);
                    for (i = 0; i < k; i++)
                        stream.insert(stream.size(), pat_bytes[8*i +: 8]);
                    stream.insert(stream.size(), alphabet[$urandom_range(2)]);
                end
                else if (r < 80)
                begin
                    stream.insert(stream.size(), alphabet[$urandom_range(2)]);
                end
                else
                begin
                    stream.insert(stream.size(), 8'($urandom_range(255)));
                end
            end
            // a stream left open carries its window into the next phase
            closed = ($urandom_range(9) != 0);
            for (i = 0; i < stream.size(); i++)
                queue_byte(stream[i], closed && (i == stream.size() - 1));
            made += stream.size();
        end
    endtask

    initial
    begin
        int i;
        rst_n          = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        pat_bytes      = '0;
        pat_len        = 4'd1;
        rep_bytes      = '0;
        rep_len        = 4'd0;
        set_idle(0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: pattern 00, empty replacement; hit at end gives empty marker
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h5A, 1'b1);
        wait_idle();

        // zero pattern length acts as 1, oversize replacement length saturates
        write_reg(CFG_PATTERN_LENGTH, 64'h0);
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_00FF);
        write_reg(CFG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'hF);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // oversize pattern length saturates to the full window
        write_reg(CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PATTERN_BYTES, 64'h8070_6050_4030_2010);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'h2);
        for (i = 0; i < 8; i++) queue_byte(8'((i + 1) * 16), 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h20, 1'b0);
        wait_idle();

        // window holds two bytes: pattern writes must be dropped
        write_reg(CFG_PATTERN_LENGTH, 64'h1);
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_0010);
        write_reg(CFG_UNUSED, 64'hDEAD_BEEF_0000_0001);
        queue_byte(8'h30, 1'b1);
        wait_idle();

        for (i = 0; i < NUM_PHASES; i++)
        begin
            set_idle(i * 3 / NUM_PHASES);
            random_config(i);
            random_streams(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("stream_pattern_replace verification clean");
        else
            $display("stream_pattern_replace verification failed");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("stream_pattern_replace verification failed");
        $finish;
    end

endmodule
